// ===== src/bce_pkg.sv =====
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types and constants for the Bezier curve evaluator.
// ----------------------------------------------------------------------------
package bce_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_CURVE_ORDER   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SEGMENT_COUNT = 3'd4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [16:0] T_ONE = 17'd65536;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_term;   // set product to one, set up term k
    logic mul_step;     // one product multiply
    logic basis_step;   // scale product by the binomial coefficient
    logic mac_x;        // multiply-accumulate x
    logic mac_y;        // multiply-accumulate y
    logic clear_acc;    // clear both accumulators
    logic finish;       // round, saturate and present the result
    logic use_u;        // multiply by u instead of t
  } bce_cmd_t;

  // Rows 0 to 15 of Pascal's triangle, built once by additions.
  function automatic logic [15:0][15:0][13:0] pascal_rows();
    logic [15:0][15:0][13:0] tab;
    tab = '0;
    for (int n = 0; n < 16; n++) begin
      tab[n][0] = 14'd1;
      for (int k = 1; k <= n; k++) begin
        tab[n][k] = tab[n-1][k-1] + tab[n-1][k];
      end
    end
    return tab;
  endfunction

  // Constant table of C(n,k), indexed [n][k].
  localparam logic [15:0][15:0][13:0] BINOM_TAB = pascal_rows();

endpackage

// ===== src/bce_datapath.sv =====
// ----------------------------------------------------------------------------
// bce_datapath
// Control-point store, product chain, basis scaling and two accumulators.
// ----------------------------------------------------------------------------
module bce_datapath #(
  parameter int unsigned MAX_ORDER    = 7,
  parameter int unsigned MAX_SEGMENTS = 16,
  parameter int unsigned SEG_W        = 4,
  parameter int unsigned PT_W         = 3,
  parameter int unsigned ADDR_W       = 7
) (
  input  logic                clk,
  input  logic                ld_we,
  input  logic [ADDR_W-1:0]   ld_addr,
  input  logic signed [31:0]  ld_x,
  input  logic signed [31:0]  ld_y,
  input  logic [ADDR_W-1:0]   rd_addr,
  input  logic [16:0]         t_val,
  input  logic [3:0]          order_n,
  input  logic [3:0]          term_k,
  input  bce_pkg::bce_cmd_t   cmd,
  input  logic                err_in,
  output logic signed [31:0]  x_out,
  output logic signed [31:0]  y_out
);
  import bce_pkg::*;

  localparam int unsigned DEPTH = MAX_SEGMENTS * (MAX_ORDER + 1);

  logic signed [31:0] mem_x [DEPTH];
  logic signed [31:0] mem_y [DEPTH];
  logic signed [31:0] rdx_r, rdy_r;

  logic [32:0] p_r, p_nxt;
  logic [32:0] b_r;
  logic signed [71:0] accx_r, accy_r;
  logic signed [65:0] prod_r;
  logic macy_d_r;
  logic [16:0] u_val, fac;
  logic [49:0] pm;
  logic [46:0] bm;

  always_ff @(posedge clk) begin
    if (ld_we) begin
      mem_x[ld_addr] <= ld_x;
      mem_y[ld_addr] <= ld_y;
    end
    rdx_r <= mem_x[rd_addr];
    rdy_r <= mem_y[rd_addr];
  end

  assign u_val = T_ONE - t_val;
  assign fac   = cmd.use_u ? u_val : t_val;
  assign pm    = 50'(p_r) * 50'(fac) + 50'd32768;
  assign bm    = 47'(p_r) * 47'(BINOM_TAB[order_n][term_k]) + 47'd2;

  always_comb begin
    p_nxt = p_r;
    if (cmd.start_term) p_nxt = 33'h1_0000_0000;
    else if (cmd.mul_step) p_nxt = pm[48:16];
  end

  // The y product is added in the cycle after it is formed.
  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    macy_d_r <= cmd.mac_y;
    if (cmd.basis_step) b_r <= bm[34:2];
    if (cmd.mac_x) prod_r <= $signed({{34{rdx_r[31]}}, rdx_r}) * $signed({1'b0, b_r});
    if (cmd.mac_y) prod_r <= $signed({{34{rdy_r[31]}}, rdy_r}) * $signed({1'b0, b_r});
    if (cmd.clear_acc) begin
      accx_r <= '0;
      accy_r <= '0;
    end else begin
      if (cmd.mac_y) accx_r <= accx_r + 72'(prod_r);
      if (macy_d_r) accy_r <= accy_r + 72'(prod_r);
    end
  end

  function automatic logic signed [31:0] sat(input logic signed [71:0] a);
    logic signed [71:0] r;
    r = (a + 72'sd536870912) >>> 30;
    if (r > 72'sd2147483647) return 32'sh7FFF_FFFF;
    if (r < -72'sd2147483648) return 32'sh8000_0000;
    return r[31:0];
  endfunction

  // Final y sum includes the last pending product.
  logic signed [71:0] accy_fin;
  assign accy_fin = accy_r + 72'(prod_r);

  always_ff @(posedge clk) begin
    if (cmd.finish && cmd.mac_x) begin
      x_out <= err_in ? '0 : sat(accx_r);
      y_out <= err_in ? '0 : sat(accy_fin);
    end
  end

  logic unused;
  assign unused = ^{SEG_W, PT_W};
endmodule

// ===== src/bce_control.sv =====
// ----------------------------------------------------------------------------
// bce_control
// Sequencer for evaluations and range errors over terms and multiply steps.
// ----------------------------------------------------------------------------
module bce_control (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go_eval,
  input  logic              go_err,
  input  logic [3:0]        order_n,
  output logic              busy,
  output logic [3:0]        term_k,
  output bce_pkg::bce_cmd_t cmd,
  output logic              strobe
);
  import bce_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_TERM  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_BASIS = 8'b0000_1000,
    S_MACX  = 8'b0001_0000,
    S_MACY  = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] k_r, k_nxt, i_r, i_nxt;

  assign term_k = k_r;
  assign busy   = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r;
    i_nxt = i_r;
    cmd = '0;
    strobe = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        k_nxt = '0;
        if (go_err) state_nxt = S_FIN;
        else if (go_eval) begin
          cmd.clear_acc = 1'b1;
          state_nxt = S_TERM;
        end
      end
      S_TERM: begin
        cmd.start_term = 1'b1;
        i_nxt = '0;
        state_nxt = (order_n == 4'd0) ? S_BASIS : S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.use_u = i_r >= k_r;
        i_nxt = i_r + 4'd1;
        if (i_r + 4'd1 == order_n) state_nxt = S_BASIS;
      end
      S_BASIS: begin
        cmd.basis_step = 1'b1;
        state_nxt = S_MACX;
      end
      S_MACX: begin
        cmd.mac_x = 1'b1;
        state_nxt = S_MACY;
      end
      S_MACY: begin
        cmd.mac_y = 1'b1;
        if (k_r == order_n) state_nxt = S_FIN;
        else begin
          k_nxt = k_r + 4'd1;
          state_nxt = S_TERM;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        cmd.mac_x = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        strobe = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r <= '0;
      i_r <= '0;
    end else begin
      state_r <= state_nxt;
      k_r <= k_nxt;
      i_r <= i_nxt;
    end
  end

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    strobe |=> !strobe) else $error("strobe held");
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> k_r <= order_n) else $error("term index past order");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> strobe) else $error("finish not followed by result");
endmodule

// ===== src/bezier_curve_evaluator.sv =====
// ----------------------------------------------------------------------------
// bezier_curve_evaluator
// Piecewise two-axis Bezier curve evaluator in Bernstein form.
// ----------------------------------------------------------------------------
// A load item (op 0) writes one control point; busy stays low. An evaluate
// item (op 1) of order n forms each Bernstein term on the single shared
// product multiplier, one factor per cycle, then a coefficient scale and one
// shared multiply-accumulate per axis. A range error skips the terms. The
// result appears for one cycle with out_valid high and cannot be stalled, so
// the receiver must take it then. Configuration is to be written only while
// busy is low, which the block itself does not enforce; the control-point
// store has no reset and must be loaded first.
module bezier_curve_evaluator #(
  parameter int unsigned MAX_ORDER    = 7,
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [3:0]         in_segment,
  input  logic [2:0]         in_point_index,
  input  logic signed [31:0] in_x_point,
  input  logic signed [31:0] in_y_point,
  input  logic [16:0]        in_t_param,
  output logic               out_valid,
  output logic signed [31:0] out_x_position,
  output logic signed [31:0] out_y_position,
  output logic               out_range_error,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [bce_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bce_pkg::*;

  localparam int unsigned PT_W   = $clog2(MAX_ORDER + 1);
  localparam int unsigned SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned ADDR_W = $clog2(MAX_SEGMENTS * (MAX_ORDER + 1));

  logic [2:0] cfg_order_r;
  logic [4:0] cfg_count_r;
  logic       err_r;
  logic [16:0] t_r;
  logic [3:0]  seg_r;
  logic [3:0]  order_n;
  logic [3:0]  term_k;
  bce_cmd_t    cmd;
  logic        strobe;
  logic        accept, go_eval, go_err, in_range, ld_we;
  logic [8:0]  cnt;

  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    unique case (paddr)
      REG_CURVE_ORDER:   prdata = 32'(cfg_order_r);
      REG_SEGMENT_COUNT: prdata = 32'(cfg_count_r);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_order_r <= 3'd5;
      cfg_count_r <= 5'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr == REG_CURVE_ORDER) cfg_order_r <= pwdata[2:0];
      if (paddr == REG_SEGMENT_COUNT) cfg_count_r <= pwdata[4:0];
    end
  end

  assign order_n = (32'(cfg_order_r) > MAX_ORDER) ? 4'(MAX_ORDER) : 4'(cfg_order_r);
  assign cnt     = (32'(cfg_count_r) > MAX_SEGMENTS) ? 9'(MAX_SEGMENTS) : 9'(cfg_count_r);
  assign accept  = start && !busy;
  assign in_range = 9'(in_segment) < cnt;
  assign go_eval = accept && in_op == OP_EVAL && in_range;
  assign go_err  = accept && in_op == OP_EVAL && !in_range;
  assign ld_we   = accept && in_op == OP_LOAD && 32'(in_segment) < MAX_SEGMENTS
                   && 32'(in_point_index) <= MAX_ORDER;

  always_ff @(posedge clk) begin
    if (accept) begin
      t_r   <= (in_t_param > T_ONE) ? T_ONE : in_t_param;
      seg_r <= in_segment;
      err_r <= !in_range;
    end
  end

  logic [ADDR_W-1:0] ld_addr, rd_addr;
  assign ld_addr = ADDR_W'(32'(in_segment) * (MAX_ORDER + 1) + 32'(in_point_index));
  assign rd_addr = ADDR_W'(32'(seg_r) * (MAX_ORDER + 1) + 32'(term_k));

  bce_control u_ctrl (
    .clk, .rst_n, .go_eval, .go_err, .order_n,
    .busy, .term_k, .cmd, .strobe
  );

  bce_datapath #(
    .MAX_ORDER(MAX_ORDER), .MAX_SEGMENTS(MAX_SEGMENTS),
    .SEG_W(SEG_W), .PT_W(PT_W), .ADDR_W(ADDR_W)
  ) u_dp (
    .clk, .ld_we, .ld_addr, .ld_x(in_x_point), .ld_y(in_y_point),
    .rd_addr, .t_val(t_r), .order_n, .term_k, .cmd, .err_in(err_r),
    .x_out(out_x_position), .y_out(out_y_position)
  );

  assign out_valid       = strobe;
  assign out_range_error = err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |-> (out_x_position == 0 && out_y_position == 0))
    else $error("range error with nonzero result");
  a_busy_eval: assert property (@(posedge clk) disable iff (!rst_n)
    go_eval |=> busy) else $error("evaluation not started");
  a_no_ld_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !ld_we) else $error("load while busy");
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the piecewise Bezier curve evaluator.
// ----------------------------------------------------------------------------
// Control points are loaded and curves are evaluated through the command
// port. The bench runs a directed table first and then random traffic under
// a series of order and segment-count settings. Evaluate items are predicted
// by a bit-exact Bernstein model kept in the bench or set in the directed
// table; each strobed result is compared with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;
  import bce_pkg::*;

  localparam int NPTS     = 8;
  localparam int NSEGS    = 16;
  localparam int WD_LIMIT = 5000;
  // Long enough for the slowest evaluate (order 7), with some margin.
  localparam int DRAIN    = 120;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               err;
  } position_t;

  typedef struct {
    logic               op;
    logic [3:0]         seg;
    logic [2:0]         pt;
    logic [31:0]        x;
    logic [31:0]        y;
    logic [16:0]        t;
    bit                 typed;
    position_t          want;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = OP_LOAD;
  logic [3:0] in_segment = '0;
  logic [2:0] in_point_index = '0;
  logic signed [31:0] in_x_point = '0;
  logic signed [31:0] in_y_point = '0;
  logic [16:0] in_t_param = '0;
  logic out_valid;
  logic signed [31:0] out_x_position;
  logic signed [31:0] out_y_position;
  logic out_range_error;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bezier_curve_evaluator dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the block's state: control-point store, which entries have
  // been written, and the two configuration registers.
  logic signed [31:0] pts_x [NSEGS*NPTS];
  logic signed [31:0] pts_y [NSEGS*NPTS];
  bit                 loaded [NSEGS*NPTS];
  logic [2:0]         order_reg;
  logic [4:0]         count_reg;
  logic [63:0]        pascal [NPTS][NPTS];

  position_t pending_positions[$];
  int  errors = 0;
  int  idle_cycles = 0;

  function automatic void build_pascal();
    for (int i = 0; i < NPTS; i++) begin
      for (int j = 0; j < NPTS; j++) pascal[i][j] = 0;
      pascal[i][0] = 1;
      for (int j = 1; j <= i; j++)
        pascal[i][j] = pascal[i-1][j-1] + (j < i ? pascal[i-1][j] : 0);
    end
  endfunction

  function automatic int eff_count();
    return (count_reg < NSEGS) ? int'(count_reg) : NSEGS;
  endfunction

  // Round half up from Q.46 to Q16.16 and clamp to 32 bits.
  function automatic logic signed [31:0] round_sat(input logic signed [95:0] acc);
    logic signed [95:0] r;
    r = (acc + (96'sd1 <<< 29)) >>> 30;
    if (r > 96'sd2147483647) r = 96'sd2147483647;
    if (r < -96'sd2147483648) r = -96'sd2147483648;
    return r[31:0];
  endfunction

  function automatic position_t bernstein_position(input logic [3:0] seg,
                                                   input logic [16:0] t_in);
    position_t res;
    logic [63:0] tt, uu, p, b;
    logic signed [95:0] ax, ay, bs, px, py;
    int n;
    res.x = 0; res.y = 0; res.err = 1'b1;
    if (int'(seg) >= eff_count()) return res;
    res.err = 1'b0;
    tt = (t_in > T_ONE) ? 64'd65536 : 64'(t_in);
    uu = 64'd65536 - tt;
    n = int'(order_reg);
    ax = 0; ay = 0;
    for (int k = 0; k <= n; k++) begin
      p = 64'd1 << 32;
      for (int i = 0; i < k; i++) p = (p * tt + 64'd32768) >> 16;
      for (int i = 0; i < n - k; i++) p = (p * uu + 64'd32768) >> 16;
      b = (pascal[n][k] * p + 64'd2) >> 2;
      bs = 96'(b);
      px = pts_x[seg*NPTS+k];
      py = pts_y[seg*NPTS+k];
      ax = ax + px * bs;
      ay = ay + py * bs;
    end
    res.x = round_sat(ax);
    res.y = round_sat(ay);
    return res;
  endfunction

  // Result checker: the receiver never stalls, so every strobe is taken.
  always @(posedge clk) begin
    position_t w;
    if (rst_n && out_valid) begin
      if (pending_positions.size() == 0) begin
        $error("unexpected result x=%0d y=%0d err=%0b",
               out_x_position, out_y_position, out_range_error);
        errors++;
      end else begin
        w = pending_positions.pop_front();
        if (out_x_position !== w.x) begin
          $error("x_position expected %0d actual %0d", w.x, out_x_position);
          errors++;
        end
        if (out_y_position !== w.y) begin
          $error("y_position expected %0d actual %0d", w.y, out_y_position);
          errors++;
        end
        if (out_range_error !== w.err) begin
          $error("range_error expected %0b actual %0b", w.err, out_range_error);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which no item, result or register write moves.
  always @(posedge clk) begin
    if ((start && !busy) || (rst_n && out_valid) || (psel && penable && pwrite))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("[bezier_curve_evaluator] ERROR");
      $finish;
    end
  end

  task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // The register takes the value at this edge because pready is tied high.
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == REG_CURVE_ORDER) order_reg = data[2:0];
    else if (addr == REG_SEGMENT_COUNT) count_reg = data[4:0];
  endtask

  // Issue one command after a random gap and update the shadow once the
  // block accepts it. A back-to-back item keeps start high throughout.
  task automatic send_cmd(input cmd_row_t c);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= c.op; in_segment <= c.seg; in_point_index <= c.pt;
    in_x_point <= c.x; in_y_point <= c.y; in_t_param <= c.t;
    do @(posedge clk); while (busy);
    if (c.op == OP_LOAD) begin
      pts_x[c.seg*NPTS+c.pt] = c.x;
      pts_y[c.seg*NPTS+c.pt] = c.y;
      loaded[c.seg*NPTS+c.pt] = 1'b1;
    end else if (c.typed) begin
      pending_positions.push_back(c.want);
    end else begin
      pending_positions.push_back(bernstein_position(c.seg, c.t));
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
  endtask

  function automatic cmd_row_t mk(input logic op, input logic [3:0] seg,
                                  input logic [2:0] pt, input logic [31:0] x,
                                  input logic [31:0] y, input logic [16:0] t);
    cmd_row_t c;
    c.op = op; c.seg = seg; c.pt = pt; c.x = x; c.y = y; c.t = t;
    c.typed = 1'b0; c.want = '{0, 0, 1'b0};
    return c;
  endfunction

  function automatic cmd_row_t mk_typed(input logic [3:0] seg, input logic [16:0] t,
                                        input logic [31:0] x, input logic [31:0] y,
                                        input logic err);
    cmd_row_t c;
    c = mk(OP_EVAL, seg, 3'd0, '0, '0, t);
    c.typed = 1'b1; c.want = '{x, y, err};
    return c;
  endfunction

  // Random command: mostly evaluations of fully loaded segments. When an
  // in-range segment still lacks a point, the missing point is loaded instead,
  // so the never-written part of the store is never read.
  function automatic cmd_row_t random_cmd();
    cmd_row_t c;
    logic [16:0] t;
    t = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    c = mk(($urandom_range(0, 9) < 4) ? OP_LOAD : OP_EVAL, 4'($urandom),
           3'($urandom), $urandom, $urandom, t);
    if (c.op == OP_EVAL && int'(c.seg) < eff_count()) begin
      for (int k = int'(order_reg); k >= 0; k--) begin
        if (!loaded[c.seg*NPTS+k]) begin
          c.op = OP_LOAD;
          c.pt = 3'(k);
        end
      end
    end
    return c;
  endfunction

  cmd_row_t directed [$];
  int unsigned phase_order [8] = '{7, 1, 0, 3, 2, 6, 4, 7};
  int unsigned phase_count [8] = '{16, 16, 8, 31, 0, 12, 3, 1};

  initial begin
    build_pascal();
    order_reg = 3'd5;
    count_reg = 5'd1;
    for (int i = 0; i < NSEGS*NPTS; i++) begin
      pts_x[i] = 0; pts_y[i] = 0; loaded[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Segment 0 gets extreme points; with the reset order of 5, t of zero
    // returns P0 and t of one (or anything above one) returns P5 exactly.
    directed.push_back(mk(OP_LOAD, 4'd0, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000, '0));
    directed.push_back(mk(OP_LOAD, 4'd0, 3'd1, 32'h8000_0000, 32'h7FFF_FFFF, '0));
    directed.push_back(mk(OP_LOAD, 4'd0, 3'd2, 32'h0000_0000, 32'hFFFF_FFFF, '0));
    directed.push_back(mk(OP_LOAD, 4'd0, 3'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0));
    directed.push_back(mk(OP_LOAD, 4'd0, 3'd4, 32'h8000_0000, 32'h8000_0000, '0));
    directed.push_back(mk(OP_LOAD, 4'd0, 3'd5, 32'h0001_0000, 32'hFFFF_0000, '0));
    directed.push_back(mk(OP_LOAD, 4'd0, 3'd6, 32'h1234_5678, 32'hEDCB_A988, '0));
    directed.push_back(mk(OP_LOAD, 4'd0, 3'd7, 32'hFFFF_FFFF, 32'h0000_0001, '0));
    directed.push_back(mk_typed(4'd0, 17'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    directed.push_back(mk_typed(4'd0, T_ONE, 32'h0001_0000, 32'hFFFF_0000, 1'b0));
    directed.push_back(mk_typed(4'd0, 17'h1FFFF, 32'h0001_0000, 32'hFFFF_0000, 1'b0));
    directed.push_back(mk(OP_EVAL, 4'd0, 3'd0, '0, '0, 17'd32768));
    directed.push_back(mk(OP_EVAL, 4'd0, 3'd7, '1, '1, 17'd1));
    directed.push_back(mk(OP_EVAL, 4'd0, 3'd0, '0, '0, 17'd65535));
    // Segments at or past the count come back as range errors with zeros.
    directed.push_back(mk_typed(4'd1, 17'd100, 32'd0, 32'd0, 1'b1));
    directed.push_back(mk_typed(4'd15, T_ONE, 32'd0, 32'd0, 1'b1));
    directed.push_back(mk(OP_LOAD, 4'd15, 3'd7, 32'h8000_0000, 32'h7FFF_FFFF, '1));
    directed.push_back(mk(OP_EVAL, 4'd0, 3'd0, '0, '0, 17'd16384));
    foreach (directed[i]) send_cmd(directed[i]);

    // Random traffic over several register settings, including order zero,
    // a zero segment count and a count above the store size.
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      repeat (DRAIN) @(posedge clk);
      reg_write(REG_CURVE_ORDER, phase_order[ph]);
      reg_write(REG_SEGMENT_COUNT, phase_count[ph]);
      for (int i = 0; i < 125; i++) begin
        // Midway through, hold the sender until the block has emptied.
        if (i == 60) drain_results();
        send_cmd(random_cmd());
      end
    end

    drain_results();
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("[bezier_curve_evaluator] OK");
    end else begin
      $display("[bezier_curve_evaluator] ERROR");
    end
    $finish;
  end

endmodule
